FILE: hdl/hte_pkg.sv
// Shared types, constants and codes of the hover thrust estimator.
// No dependencies; hte_front, hte_queue, hte_back and the top refer to it by scoped names.
package hte_pkg;

   localparam int WINDOW_LEN_DEFAULT = 10;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_ADDR_W         = 5;

   // 9.8 in Q16
   localparam logic [19:0] G_Q16 = 20'd642253;

   localparam logic [1:0] ST_ARM    = 2'd0;
   localparam logic [1:0] ST_EST    = 2'd1;
   localparam logic [1:0] ST_ACCEPT = 2'd2;
   localparam logic [1:0] ST_RANGE  = 2'd3;

   localparam logic [2:0] REG_INIT_THRUST = 3'd0;
   localparam logic [2:0] REG_INIT_VAR    = 3'd1;
   localparam logic [2:0] REG_PROC_NOISE  = 3'd2;
   localparam logic [2:0] REG_MEAS_NOISE  = 3'd3;
   localparam logic [2:0] REG_SPREAD_TOL  = 3'd4;

   localparam logic [15:0] RST_INIT_THRUST = 16'd19661;
   localparam logic [31:0] RST_INIT_VAR    = 32'd26843546;
   localparam logic [31:0] RST_PROC_NOISE  = 32'd26844;
   localparam logic [31:0] RST_MEAS_NOISE  = 32'd2684355;
   localparam logic [15:0] RST_SPREAD_TOL  = 16'd328;

   typedef struct packed {
      logic               arm;
      logic [15:0]        thrust;
      logic signed [31:0] az;
   } hte_job_type;

   typedef struct packed {
      logic [15:0] init_thrust;
      logic [31:0] init_var;
      logic [31:0] proc_noise;
      logic [31:0] meas_noise;
      logic [15:0] spread_tol;
   } hte_cfg_type;

endpackage

FILE: hdl/hte_if.sv
// Valid/ready channel interfaces for the estimator's input and result items.
// Depends on nothing.
interface hte_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        commanded_thrust;
   logic signed [15:0] quat_w;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   modport source(output valid, commanded_thrust, quat_w, quat_x, quat_y, quat_z,
                  accel_x, accel_y, accel_z, input ready);
   modport sink(input valid, commanded_thrust, quat_w, quat_x, quat_y, quat_z,
                accel_x, accel_y, accel_z, output ready);
endinterface

interface hte_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [23:0] new_estimate;
   logic [15:0]        hover_fraction;
   logic [31:0]        variance;
   modport source(output valid, status, new_estimate, hover_fraction, variance,
                  input ready);
   modport sink(input valid, status, new_estimate, hover_fraction, variance,
                output ready);
endinterface

FILE: hdl/hte_front.sv
// Front end: accepts input beats, flags the arming beat and rotates the body
// acceleration to world vertical acceleration. Uses hte_pkg and hte_req_if.
module hte_front (
   input  logic                 clock,
   input  logic                 reset,
   hte_req_if.sink              req_ch,
   output logic                 push_valid,
   output hte_pkg::hte_job_type push_job,
   input  logic                 push_ready
);

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_PROD = 3'd1;
   localparam logic [2:0] F_ROT  = 3'd2;
   localparam logic [2:0] F_MUL  = 3'd3;
   localparam logic [2:0] F_SUM  = 3'd4;
   localparam logic [2:0] F_PUSH = 3'd5;

   logic [2:0] phase_ff, phase_in;
   logic       armed_ff, armed_in;

   logic               arm_ff;
   logic [15:0]        thrust_ff;
   logic signed [15:0] qw_ff, qx_ff, qy_ff, qz_ff, ax_ff, ay_ff, azb_ff;
   logic signed [31:0] pxz_ff, pwy_ff, pyz_ff, pwx_ff, pww_ff, pxx_ff, pyy_ff, pzz_ff;
   logic signed [33:0] r20_ff, r21_ff, r22_ff;
   logic signed [49:0] m0_ff, m1_ff, m2_ff;
   logic signed [51:0] sum_w;
   hte_pkg::hte_job_type job_ff;

   logic accept;

   assign req_ch.ready = (phase_ff == F_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign push_valid   = (phase_ff == F_PUSH);
   assign push_job     = job_ff;
   assign sum_w        = 52'(m0_ff) + 52'(m1_ff) + 52'(m2_ff);

   always_comb begin
      phase_in = phase_ff;
      armed_in = armed_ff;
      case (phase_ff)
         F_IDLE: begin
            if (accept) begin
               phase_in = F_PROD;
               armed_in = 1'b1;
            end
         end
         F_PROD: phase_in = F_ROT;
         F_ROT:  phase_in = F_MUL;
         F_MUL:  phase_in = F_SUM;
         F_SUM:  phase_in = F_PUSH;
         F_PUSH: begin
            if (push_ready) phase_in = F_IDLE;
         end
         default: phase_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= F_IDLE;
         armed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         arm_ff    <= !armed_ff;
         thrust_ff <= req_ch.commanded_thrust;
         qw_ff     <= req_ch.quat_w;
         qx_ff     <= req_ch.quat_x;
         qy_ff     <= req_ch.quat_y;
         qz_ff     <= req_ch.quat_z;
         ax_ff     <= req_ch.accel_x;
         ay_ff     <= req_ch.accel_y;
         azb_ff    <= req_ch.accel_z;
      end
      pxz_ff <= qx_ff * qz_ff;
      pwy_ff <= qw_ff * qy_ff;
      pyz_ff <= qy_ff * qz_ff;
      pwx_ff <= qw_ff * qx_ff;
      pww_ff <= qw_ff * qw_ff;
      pxx_ff <= qx_ff * qx_ff;
      pyy_ff <= qy_ff * qy_ff;
      pzz_ff <= qz_ff * qz_ff;
      r20_ff <= (34'(pxz_ff) - 34'(pwy_ff)) <<< 1;
      r21_ff <= (34'(pyz_ff) + 34'(pwx_ff)) <<< 1;
      r22_ff <= 34'(pww_ff) - 34'(pxx_ff) - 34'(pyy_ff) + 34'(pzz_ff);
      m0_ff  <= r20_ff * ax_ff;
      m1_ff  <= r21_ff * ay_ff;
      m2_ff  <= r22_ff * azb_ff;
      if (phase_ff == F_SUM) begin
         job_ff.arm    <= arm_ff;
         job_ff.thrust <= thrust_ff;
         // floor divide by 2^20
         job_ff.az     <= sum_w[51:20];
      end
   end

endmodule

FILE: hdl/hte_queue.sv
// Short job queue between front and back ends.
// Uses hte_pkg for the job type and depth.
module hte_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  hte_pkg::hte_job_type push_job,
   output logic                 push_ready,
   output logic                 pop_valid,
   output hte_pkg::hte_job_type pop_job,
   input  logic                 pop_ready
);

   localparam int PW = $clog2(hte_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(hte_pkg::QUEUE_DEPTH + 1);

   hte_pkg::hte_job_type slot_ff [hte_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(hte_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PW'(hte_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PW'(hte_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(do_push) - CW'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

endmodule

FILE: hdl/hte_muldiv.sv
// Shared multiply-divide unit: floor(a*b/c) or floor(a*b/2^16), saturated at
// 2^64-1. The four 32x32 partial products are summed in turn, then one quotient bit a cycle.
module hte_muldiv (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        shift_mode,
   input  logic [63:0] opa,
   input  logic [63:0] opb,
   input  logic [63:0] opc,
   output logic        busy,
   output logic        done,
   output logic [63:0] result
);

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_MUL  = 2'd1;
   localparam logic [1:0] M_CHK  = 2'd2;
   localparam logic [1:0] M_DIV  = 2'd3;

   logic [1:0]   phase_ff, phase_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         done_ff, done_in;
   logic [63:0]  a_ff, b_ff, c_ff, res_ff, res_in;
   logic         mode_ff;
   logic [127:0] acc_ff, acc_in;

   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [127:0] term;
   logic [64:0]  shifted;
   logic         qbit;

   assign busy   = (phase_ff != M_IDLE);
   assign done   = done_ff;
   assign result = res_ff;

   assign a_half  = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_half  = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];
   assign pp      = a_half * b_half;
   assign shifted = {acc_ff[127:64], acc_ff[63]};
   assign qbit    = (shifted >= {1'b0, c_ff});

   always_comb begin
      term = {64'd0, pp};
      case (cnt_ff[1:0])
         2'd0:    term = {64'd0, pp};
         2'd3:    term = {pp, 64'd0};
         default: term = {32'd0, pp, 32'd0};
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (phase_ff)
         M_IDLE: begin
            if (start) begin
               phase_in = M_MUL;
               cnt_in   = '0;
               acc_in   = '0;
            end
         end
         M_MUL: begin
            acc_in = acc_ff + term;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[1:0] == 2'd3) phase_in = M_CHK;
         end
         M_CHK: begin
            cnt_in = '0;
            if (mode_ff) begin
               res_in   = (acc_ff[127:80] != '0) ? '1 : acc_ff[79:16];
               done_in  = 1'b1;
               phase_in = M_IDLE;
            end else if (c_ff == '0 || acc_ff[127:64] >= c_ff) begin
               res_in   = '1;
               done_in  = 1'b1;
               phase_in = M_IDLE;
            end else begin
               phase_in = M_DIV;
            end
         end
         M_DIV: begin
            acc_in[127:64] = qbit ? 64'(shifted - {1'b0, c_ff}) : shifted[63:0];
            acc_in[63:0]   = {acc_ff[62:0], qbit};
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == 6'd63) begin
               res_in   = {acc_ff[62:0], qbit};
               done_in  = 1'b1;
               phase_in = M_IDLE;
            end
         end
         default: phase_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
      if (start && phase_ff == M_IDLE) begin
         a_ff    <= opa;
         b_ff    <= opb;
         c_ff    <= opc;
         mode_ff <= shift_mode;
      end
   end

endmodule

FILE: hdl/hte_back.sv
// Back end: Kalman predict and correct on the hover thrust, estimate window
// and convergence check. Uses hte_pkg, hte_rsp_if and hte_muldiv.
module hte_back #(
   parameter int WINDOW_LEN = hte_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  hte_pkg::hte_cfg_type cfg,
   input  logic                 job_valid,
   input  hte_pkg::hte_job_type job,
   output logic                 job_pop,
   hte_rsp_if.source            rsp_ch
);

   localparam int IDXW  = $clog2(WINDOW_LEN);
   localparam int FILLW = $clog2(WINDOW_LEN + 1);

   localparam logic [3:0] B_IDLE  = 4'd0;
   localparam logic [3:0] B_PREP  = 4'd1;
   localparam logic [3:0] B_THR   = 4'd2;
   localparam logic [3:0] B_M     = 4'd3;
   localparam logic [3:0] B_HP    = 4'd4;
   localparam logic [3:0] B_A     = 4'd5;
   localparam logic [3:0] B_S     = 4'd6;
   localparam logic [3:0] B_DELTA = 4'd7;
   localparam logic [3:0] B_PN    = 4'd8;
   localparam logic [3:0] B_EST   = 4'd9;
   localparam logic [3:0] B_SCAN  = 4'd10;
   localparam logic [3:0] B_DONE  = 4'd11;

   logic [3:0]       state_ff, state_in;
   logic             wait_ff, wait_in;
   logic [15:0]      acc_ff, acc_in;
   logic [31:0]      var_ff, var_in;
   logic [FILLW-1:0] fill_ff, fill_in;
   logic [IDXW-1:0]  head_ff, head_in;
   logic [FILLW-1:0] scan_ff, scan_in;
   logic             rdv_ff, rdv_in;
   logic             first_ff, first_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       status_ff, status_in;

   logic [15:0]        thrust_ff, h_ff;
   logic signed [31:0] az_ff;
   logic [35:0]        gt_ff;
   logic [31:0]        hh_ff, p_ff, pn_ff;
   logic signed [37:0] innov_ff;
   logic [63:0]        m_ff, hp_ff, s_ff;
   logic [40:0]        delta_ff;
   logic signed [23:0] est_ff, lo_ff, hi_ff, rd_ff;
   logic [1:0]         out_status_ff;
   logic signed [23:0] out_est_ff;
   logic [15:0]        out_thr_ff;
   logic [31:0]        out_var_ff;

   logic signed [23:0] window [WINDOW_LEN];

   logic        md_start, md_mode, md_busy, md_done;
   logic [63:0] md_a, md_b, md_c, md_res;
   logic        op_state, scan_issue, innov_pos;
   logic [15:0] h_w;
   logic [32:0] p_sum;
   logic [64:0] s_sum;
   logic [36:0] abs_i;
   logic signed [42:0] est_w;
   logic signed [23:0] est_sat;
   logic signed [24:0] spread;

   hte_muldiv u_muldiv (
      .clock      (clock),
      .reset      (reset),
      .start      (md_start),
      .shift_mode (md_mode),
      .opa        (md_a),
      .opb        (md_b),
      .opc        (md_c),
      .busy       (md_busy),
      .done       (md_done),
      .result     (md_res)
   );

   assign op_state = (state_ff == B_THR) || (state_ff == B_M) || (state_ff == B_HP) ||
                     (state_ff == B_A) || (state_ff == B_DELTA) || (state_ff == B_PN);
   assign md_start = op_state && !wait_ff;
   assign job_pop  = (state_ff == B_IDLE) && job_valid && !out_valid_ff;

   assign h_w        = (acc_ff == '0) ? 16'd1 : acc_ff;
   assign p_sum      = {1'b0, var_ff} + {1'b0, cfg.proc_noise};
   assign s_sum      = {1'b0, md_res} + 65'(cfg.meas_noise);
   assign abs_i      = innov_ff[37] ? 37'(-innov_ff) : innov_ff[36:0];
   assign innov_pos  = !innov_ff[37] && (innov_ff != '0);
   assign est_w      = innov_pos ? $signed({27'd0, h_ff}) - $signed({2'b00, delta_ff})
                                 : $signed({27'd0, h_ff}) + $signed({2'b00, delta_ff});
   assign est_sat    = (est_w > 43'sd8388607)  ? 24'sh7FFFFF :
                       (est_w < -43'sd8388608) ? 24'sh800000 : est_w[23:0];
   assign scan_issue = (scan_ff != FILLW'(WINDOW_LEN));
   assign spread     = {hi_ff[23], hi_ff} - {lo_ff[23], lo_ff};

   always_comb begin
      md_a    = 64'(gt_ff);
      md_b    = 64'd1;
      md_c    = 64'(h_ff);
      md_mode = 1'b0;
      case (state_ff)
         B_THR: begin
            md_a = 64'(gt_ff);
            md_b = 64'd1;
            md_c = 64'(h_ff);
         end
         B_M: begin
            md_a = 64'(gt_ff);
            md_b = 64'd65536;
            md_c = 64'(hh_ff);
         end
         B_HP: begin
            md_a    = m_ff;
            md_b    = 64'(p_ff);
            md_mode = 1'b1;
         end
         B_A: begin
            md_a    = hp_ff;
            md_b    = m_ff;
            md_mode = 1'b1;
         end
         B_DELTA: begin
            md_a = hp_ff;
            md_b = 64'(abs_i);
            md_c = s_ff;
         end
         B_PN: begin
            md_a = 64'(p_ff);
            md_b = 64'(cfg.meas_noise);
            md_c = s_ff;
         end
         default: md_mode = 1'b0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wait_in      = wait_ff;
      acc_in       = acc_ff;
      var_in       = var_ff;
      fill_in      = fill_ff;
      head_in      = head_ff;
      scan_in      = scan_ff;
      rdv_in       = 1'b0;
      first_in     = first_ff;
      status_in    = status_ff;
      out_valid_in = out_valid_ff;
      if (rsp_ch.ready && out_valid_ff) out_valid_in = 1'b0;
      if (md_start) wait_in = 1'b1;
      if (md_done) wait_in = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (job_pop) begin
               if (job.arm) begin
                  acc_in    = cfg.init_thrust;
                  var_in    = cfg.init_var;
                  status_in = hte_pkg::ST_ARM;
                  state_in  = B_DONE;
               end else begin
                  state_in = B_PREP;
               end
            end
         end
         B_PREP:  state_in = B_THR;
         B_THR:   if (md_done) state_in = B_M;
         B_M:     if (md_done) state_in = B_HP;
         B_HP:    if (md_done) state_in = B_A;
         B_A:     if (md_done) state_in = B_S;
         B_S:     state_in = (s_ff == '0) ? B_EST : B_DELTA;
         B_DELTA: if (md_done) state_in = B_PN;
         B_PN:    if (md_done) state_in = B_EST;
         B_EST: begin
            var_in    = pn_ff;
            head_in   = (head_ff == IDXW'(WINDOW_LEN - 1)) ? '0 : head_ff + 1'b1;
            status_in = hte_pkg::ST_EST;
            if (fill_ff != FILLW'(WINDOW_LEN)) fill_in = fill_ff + 1'b1;
            if (fill_in == FILLW'(WINDOW_LEN)) begin
               state_in = B_SCAN;
               scan_in  = '0;
               first_in = 1'b1;
            end else begin
               state_in = B_DONE;
            end
         end
         B_SCAN: begin
            rdv_in  = scan_issue;
            scan_in = scan_ff + FILLW'(scan_issue);
            if (rdv_ff) first_in = 1'b0;
            if (!scan_issue && !rdv_ff) begin
               state_in = B_DONE;
               if (spread < 25'(cfg.spread_tol)) begin
                  if (!est_ff[23] && est_ff != '0 && est_ff[23:16] == '0) begin
                     acc_in    = est_ff[15:0];
                     status_in = hte_pkg::ST_ACCEPT;
                  end else begin
                     status_in = hte_pkg::ST_RANGE;
                  end
               end
            end
         end
         B_DONE: begin
            out_valid_in = 1'b1;
            state_in     = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         wait_ff      <= 1'b0;
         acc_ff       <= hte_pkg::RST_INIT_THRUST;
         var_ff       <= hte_pkg::RST_INIT_VAR;
         fill_ff      <= '0;
         head_ff      <= '0;
         scan_ff      <= '0;
         rdv_ff       <= 1'b0;
         first_ff     <= 1'b0;
         status_ff    <= hte_pkg::ST_ARM;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         acc_ff       <= acc_in;
         var_ff       <= var_in;
         fill_ff      <= fill_in;
         head_ff      <= head_in;
         scan_ff      <= scan_in;
         rdv_ff       <= rdv_in;
         first_ff     <= first_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         thrust_ff <= job.thrust;
         az_ff     <= job.az;
         est_ff    <= '0;
      end
      if (state_ff == B_PREP) begin
         h_ff  <= h_w;
         gt_ff <= hte_pkg::G_Q16 * thrust_ff;
         hh_ff <= h_w * h_w;
         p_ff  <= p_sum[32] ? '1 : p_sum[31:0];
      end
      if (md_done) begin
         case (state_ff)
            B_THR:   innov_ff <= $signed({{6{az_ff[31]}}, az_ff}) -
                                 $signed({2'b00, md_res[35:0]});
            B_M:     m_ff <= md_res;
            B_HP:    hp_ff <= md_res;
            B_A:     s_ff <= s_sum[64] ? '1 : s_sum[63:0];
            B_DELTA: delta_ff <= (md_res > 64'h100_0000_0000) ? 41'h100_0000_0000
                                                             : md_res[40:0];
            B_PN:    pn_ff <= md_res[31:0];
            default: pn_ff <= pn_ff;
         endcase
      end
      // zero gain when the innovation variance is zero
      if (state_ff == B_S && s_ff == '0) begin
         delta_ff <= '0;
         pn_ff    <= p_ff;
      end
      if (state_ff == B_EST) begin
         est_ff          <= est_sat;
         window[head_ff] <= est_sat;
      end
      if (state_ff == B_SCAN && scan_issue) rd_ff <= window[scan_ff[IDXW-1:0]];
      if (rdv_ff) begin
         lo_ff <= (first_ff || rd_ff < lo_ff) ? rd_ff : lo_ff;
         hi_ff <= (first_ff || rd_ff > hi_ff) ? rd_ff : hi_ff;
      end
      if (state_ff == B_DONE) begin
         out_status_ff <= status_ff;
         out_est_ff    <= est_ff;
         out_thr_ff    <= acc_ff;
         out_var_ff    <= var_ff;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_status_ff;
   assign rsp_ch.new_estimate   = out_est_ff;
   assign rsp_ch.hover_fraction = out_thr_ff;
   assign rsp_ch.variance       = out_var_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILLW'(WINDOW_LEN))
      else $error("window fill beyond window length");

   a_accept_match: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_status_ff == hte_pkg::ST_ACCEPT) |->
      (out_thr_ff == out_est_ff[15:0] && out_thr_ff != '0))
      else $error("accepted thrust differs from estimate");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> (state_ff == B_IDLE && !out_valid_ff))
      else $error("job taken while busy");

   a_md_start: assert property (@(posedge clock) disable iff (reset)
      md_start |-> !md_busy)
      else $error("divider started while busy");

endmodule

FILE: hdl/hover_thrust_kalman_estimator_top.sv
// Hover thrust estimator, top level: APB register file and the front end,
// job queue and back end. Uses hte_pkg, hte_if, hte_front, hte_queue, hte_back.
//
// The first beat after reset arms the block and answers with the initial
// hover thrust and variance. Every later beat passes through the back end
// in turn: the queue pop, setup, two divisions, two product-and-shift passes,
// the innovation variance check, two more divisions, the estimate, a window
// min/max scan once the window is full, and the result load. Each division
// in the shared multiply-divide unit has an issue step, four 32x32 partial
// products, a check, 64 quotient bits and a done step. A zero innovation
// variance skips the last two divisions. The back end takes no new job while
// its result beat waits to be taken. The front end presents the rotated job
// after its product, rotation, multiply and sum steps, and the queue holds
// up to two jobs while the back end works.
module hover_thrust_kalman_estimator_top #(
   parameter int WINDOW_LEN = hte_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   hte_req_if.sink                       req_ch,
   hte_rsp_if.source                     rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hte_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   hte_pkg::hte_cfg_type cfg_ff;
   hte_pkg::hte_job_type push_job, pop_job;
   logic                 push_valid, push_ready, pop_valid, pop_ready;
   logic [2:0]           reg_idx;
   logic                 wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.init_thrust <= hte_pkg::RST_INIT_THRUST;
         cfg_ff.init_var    <= hte_pkg::RST_INIT_VAR;
         cfg_ff.proc_noise  <= hte_pkg::RST_PROC_NOISE;
         cfg_ff.meas_noise  <= hte_pkg::RST_MEAS_NOISE;
         cfg_ff.spread_tol  <= hte_pkg::RST_SPREAD_TOL;
      end else if (wr_en) begin
         case (reg_idx)
            hte_pkg::REG_INIT_THRUST: cfg_ff.init_thrust <= csr_pwdata[15:0];
            hte_pkg::REG_INIT_VAR:    cfg_ff.init_var    <= csr_pwdata;
            hte_pkg::REG_PROC_NOISE:  cfg_ff.proc_noise  <= csr_pwdata;
            hte_pkg::REG_MEAS_NOISE:  cfg_ff.meas_noise  <= csr_pwdata;
            hte_pkg::REG_SPREAD_TOL:  cfg_ff.spread_tol  <= csr_pwdata[15:0];
            default:                  cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         hte_pkg::REG_INIT_THRUST: csr_prdata = {16'd0, cfg_ff.init_thrust};
         hte_pkg::REG_INIT_VAR:    csr_prdata = cfg_ff.init_var;
         hte_pkg::REG_PROC_NOISE:  csr_prdata = cfg_ff.proc_noise;
         hte_pkg::REG_MEAS_NOISE:  csr_prdata = cfg_ff.meas_noise;
         hte_pkg::REG_SPREAD_TOL:  csr_prdata = {16'd0, cfg_ff.spread_tol};
         default:                  csr_prdata = '0;
      endcase
   end

   hte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready)
   );

   hte_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop_ready  (pop_ready)
   );

   hte_back #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .job_valid (pop_valid),
      .job       (pop_job),
      .job_pop   (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule
